[hdl/lscc_pkg.sv]
// Package for the laser scanner command controller.
// Types, codes and reset constants shared by the controller, datapath and top level.
package lscc_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int DIV_WIDTH = 28;

  localparam logic [15:0] SAFE_RST = 16'd30000;
  localparam logic [15:0] MINR_RST = 16'd40;
  localparam logic [15:0] MAXR_RST = 16'd30000;
  localparam logic [23:0] CLK_RST = 24'd1200000;
  localparam logic [15:0] MAXC_RST = 16'd4095;
  localparam logic [23:0] DIVISOR_RST = 24'd39;

  // configuration register indexes
  localparam logic [2:0] REG_SAFE = 3'd0;
  localparam logic [2:0] REG_MINR = 3'd1;
  localparam logic [2:0] REG_MAXR = 3'd2;
  localparam logic [2:0] REG_CLK = 3'd3;
  localparam logic [2:0] REG_MAXC = 3'd4;

  localparam logic [3:0] CMD_MOVE = 4'd0;
  localparam logic [3:0] CMD_MUTE = 4'd3;
  localparam logic [3:0] CMD_UNMUTE = 4'd4;
  localparam logic [3:0] CMD_COLOUR = 4'd5;
  localparam logic [3:0] CMD_RATE = 4'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_HALT = 2'd2;

  localparam logic [2:0] RSN_NONE = 3'd0;
  localparam logic [2:0] RSN_NO_MOVE = 3'd1;
  localparam logic [2:0] RSN_FRAME = 3'd2;
  localparam logic [2:0] RSN_COORD = 3'd3;
  localparam logic [2:0] RSN_RATE = 3'd4;
  localparam logic [2:0] RSN_UNKNOWN = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [3:0]  command_code;
    logic [27:0] command_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  halt_reason;
    logic        mute_drive;
    logic        scan_valid;
    logic [10:0] scan_x_out;
    logic [10:0] scan_y_out;
    logic        color_valid;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item, run the load-cycle state update
    logic div_start; // start rate divide
    logic div_step;  // one restoring division step
    logic div_done;  // commit divisor and finish rate command
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div; // captured item is a valid rate command
  } dp_stat_t;

endpackage

[hdl/lscc_ctrl.sv]
// Controller state machine of the laser scanner command controller.
// Sequences item load, the serial rate divide and result hand-off. Uses lscc_pkg.
module lscc_ctrl
  import lscc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_OUT} state_t;

  state_t     state;
  logic [4:0] step;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.div_start = (state == S_CHECK) && stat.need_div;
    cmd.div_step = (state == S_DIV);
    cmd.div_done = (state == S_DIV) && (step == 5'(DIV_WIDTH - 1));
  end

  // state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          step <= '0;
          state <= stat.need_div ? S_DIV : S_OUT;
        end
        S_DIV: begin
          step <= step + 5'd1;
          if (step == 5'(DIV_WIDTH - 1)) state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/lscc_dp.sv]
// Datapath of the laser scanner command controller: state, config checks,
// serial divider and result register. Uses lscc_pkg.
module lscc_dp
  import lscc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_item,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [15:0] safe_ticks,
  input  logic [15:0] min_rate,
  input  logic [15:0] max_rate,
  input  logic [23:0] clk_hz,
  input  logic [15:0] max_coord,
  output out_item_t   out_item
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  logic        halted_flag, muted_flag, mute_line, frame_ready, move_pending;
  logic [2:0]  halt_code;
  logic [15:0] last_x, last_y;
  logic [7:0]  last_red, last_green, last_blue;
  logic [COUNTER_WIDTH-1:0] ticks_since_move, frame_wait_ticks;
  logic [23:0] frame_divisor, frame_countdown;
  logic [31:0] pending_coords;
  logic        need_div;

  // divider registers
  logic [DIV_WIDTH-1:0] dividend, quot, divisor_r;
  logic [DIV_WIDTH:0]   rem;
  logic [DIV_WIDTH:0]   trial;
  logic [DIV_WIDTH-1:0] quot_final;

  // next-state of the load-cycle state update
  logic        halted_next, muted_next, mute_line_next, ready_next, pending_next;
  logic [2:0]  code_next;
  logic [15:0] x_next, y_next;
  logic [7:0]  r_next, g_next, b_next;
  logic [COUNTER_WIDTH-1:0] tsm_next, fwt_next;
  logic [23:0] cd_next;
  logic [31:0] pc_next;
  logic [1:0]  status_next;
  logic        scan_next, color_next, need_div_next;

  assign stat.need_div = need_div;

  function automatic logic [COUNTER_WIDTH-1:0] inc_sat(input logic [COUNTER_WIDTH-1:0] v);
    inc_sat = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // one item's state update, run in the load cycle
  always_comb begin
    logic        run;
    logic [31:0] coords;
    logic [15:0] mx, my;
    logic [27:0] d;
    halted_next = halted_flag; code_next = halt_code;
    muted_next = muted_flag; mute_line_next = mute_line;
    ready_next = frame_ready; pending_next = move_pending;
    x_next = last_x; y_next = last_y;
    r_next = last_red; g_next = last_green; b_next = last_blue;
    tsm_next = ticks_since_move; fwt_next = frame_wait_ticks;
    cd_next = frame_countdown; pc_next = pending_coords;
    status_next = ST_OK; scan_next = 1'b0; color_next = 1'b0;
    need_div_next = 1'b0;
    run = 1'b0; coords = pending_coords;
    d = in_item.command_data;
    if (halted_flag) begin
      status_next = ST_HALT;
    end else if (in_item.operation) begin
      tsm_next = inc_sat(ticks_since_move);
      if (!frame_ready) begin
        if (frame_countdown > 24'd0) cd_next = frame_countdown - 24'd1;
        if (cd_next == 24'd0) ready_next = 1'b1;
      end
      if (move_pending) begin
        if (ready_next) begin
          pending_next = 1'b0;
          fwt_next = '0;
          run = 1'b1;
        end else begin
          fwt_next = inc_sat(frame_wait_ticks);
          if (32'(fwt_next) >= 32'(safe_ticks)) begin
            halted_next = 1'b1; code_next = RSN_FRAME;
          end
        end
      end
    end else if (move_pending) begin
      status_next = ST_BUSY;
    end else begin
      unique case (in_item.command_code)
        CMD_MOVE: begin
          coords = {4'd0, d};
          if (frame_ready) run = 1'b1;
          else begin
            pending_next = 1'b1; pc_next = {4'd0, d}; fwt_next = '0;
          end
        end
        CMD_MUTE: muted_next = 1'b1;
        CMD_UNMUTE: muted_next = 1'b0;
        CMD_COLOUR: begin
          if (d[23:16] != last_red || d[15:8] != last_green || d[7:0] != last_blue) begin
            r_next = d[23:16]; g_next = d[15:8]; b_next = d[7:0];
            color_next = 1'b1;
          end
        end
        CMD_RATE: begin
          if (d == 28'd0 || d < {12'd0, min_rate} || d > {12'd0, max_rate}) begin
            halted_next = 1'b1; code_next = RSN_RATE;
          end else need_div_next = 1'b1;
        end
        default: begin
          halted_next = 1'b1; code_next = RSN_UNKNOWN;
        end
      endcase
    end
    // move execution
    mx = coords[31:16]; my = coords[15:0];
    if (run) begin
      ready_next = 1'b0;
      cd_next = frame_divisor;
      if (mx > max_coord || my > max_coord) begin
        halted_next = 1'b1; code_next = RSN_COORD;
      end else begin
        if (mx != last_x || my != last_y || muted_next) begin
          tsm_next = '0; x_next = mx; y_next = my;
        end
        mute_line_next = muted_next;
        scan_next = 1'b1;
      end
    end
    // watchdog
    if (!halted_next && !pending_next && !muted_next &&
        32'(tsm_next) >= 32'(safe_ticks)) begin
      halted_next = 1'b1; code_next = RSN_NO_MOVE;
    end
    if (halted_next) begin
      muted_next = 1'b1; mute_line_next = 1'b1;
      status_next = ST_HALT; scan_next = 1'b0; color_next = 1'b0;
    end
  end

  // trial subtraction and the full quotient including the last step's bit
  assign trial = {rem[DIV_WIDTH-1:0], dividend[DIV_WIDTH-1]} - {1'b0, divisor_r};
  assign quot_final = {quot[DIV_WIDTH-2:0], ~trial[DIV_WIDTH]};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      halted_flag <= 1'b0; halt_code <= RSN_NONE;
      muted_flag <= 1'b1; mute_line <= 1'b1;
      last_x <= '0; last_y <= '0;
      last_red <= '0; last_green <= '0; last_blue <= '0;
      ticks_since_move <= '0; frame_wait_ticks <= '0;
      frame_divisor <= DIVISOR_RST; frame_countdown <= '0;
      frame_ready <= 1'b1; move_pending <= 1'b0; pending_coords <= '0;
      need_div <= 1'b0;
    end else if (cmd.load) begin
      halted_flag <= halted_next; halt_code <= code_next;
      muted_flag <= muted_next; mute_line <= mute_line_next;
      last_x <= x_next; last_y <= y_next;
      last_red <= r_next; last_green <= g_next; last_blue <= b_next;
      ticks_since_move <= tsm_next; frame_wait_ticks <= fwt_next;
      frame_countdown <= cd_next; frame_ready <= ready_next;
      move_pending <= pending_next; pending_coords <= pc_next;
      need_div <= need_div_next;
    end else if (cmd.div_done) begin
      // quotient of the final step is known here
      frame_divisor <= (quot_final == '0) ? 24'd0 : 24'(quot_final - 1'b1);
    end
  end

  // restoring divider, one quotient bit per cycle; divisor taken with the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor_r <= in_item.command_data;
    end
    if (cmd.div_start) begin
      dividend <= {4'd0, clk_hz};
      rem <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[DIV_WIDTH-2:0], 1'b0};
      quot <= quot_final;
      rem <= trial[DIV_WIDTH] ? {rem[DIV_WIDTH-1:0], dividend[DIV_WIDTH-1]} : trial;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_item.status <= status_next;
      out_item.halt_reason <= halted_next ? code_next : RSN_NONE;
      out_item.mute_drive <= halted_next ? 1'b1 : mute_line_next;
      out_item.scan_valid <= scan_next;
      out_item.scan_x_out <= x_next[11:1];
      out_item.scan_y_out <= y_next[11:1];
      out_item.color_valid <= color_next;
      out_item.red_level <= r_next;
      out_item.green_level <= g_next;
      out_item.blue_level <= b_next;
    end
  end

endmodule

[hdl/laser_scanner_command_controller.sv]
// Laser scanner command controller.
//
// Input channel in_valid/in_ready carries in_item (operation, command_code,
// command_data); one command or one frame-timer tick per transfer. Output
// channel out_valid/out_ready carries one out_item per input transfer.
// Configuration: cfg_we writes cfg_data into register cfg_index at once.
//
// A tick or non-rate command goes from the check state straight to the
// output state; a valid rate command first runs the 28 steps of the serial
// restoring divider. Input is ready again in the cycle after the result
// transfer, so no new item is taken before the last result is transferred.
// A stalled receiver holds the result and blocks new input.
// Reset clears command and config state: unmuted is off (laser muted),
// frame ready, divisor 39, registers at defaults; no clearing pass is needed.
// Depends on lscc_pkg, lscc_ctrl and lscc_dp.
module laser_scanner_command_controller
  import lscc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [15:0] safe_ticks, min_rate, max_rate, max_coord;
  logic [23:0] clk_hz;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      safe_ticks <= SAFE_RST; min_rate <= MINR_RST; max_rate <= MAXR_RST;
      clk_hz <= CLK_RST; max_coord <= MAXC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAFE: safe_ticks <= cfg_data[15:0];
        REG_MINR: min_rate <= cfg_data[15:0];
        REG_MAXR: max_rate <= cfg_data[15:0];
        REG_CLK: clk_hz <= cfg_data;
        REG_MAXC: max_coord <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lscc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  lscc_dp #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_dp (
    .clk, .rst, .in_item, .cmd, .stat,
    .safe_ticks, .min_rate, .max_rate, .clk_hz, .max_coord, .out_item
  );

  // no input transfer while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // a halted result always drives mute
  a_halt_mute: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == ST_HALT) |-> out_item.mute_drive)
    else $error("halt without mute");

  // scan and colour never both flagged
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.scan_valid && out_item.color_valid))
    else $error("scan and colour in one result");

endmodule
